// ----- rtl/fwrbv_pkg.sv -----
// package: shared codes, widths and the cell control type of the remove-by-value fifo
`timescale 1ns / 1ps

package fwrbv_pkg;

  // default number of entries
  localparam int unsigned DEPTH_DEF = 16;

  // beat field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  // per-cell control
  typedef struct packed {
    logic shift;  // take the neighbour's entry
    logic load;   // take the broadcast write data
  } cell_ctrl_t;

endpackage

// ----- rtl/fwrbv_cell.sv -----
// module: one storage cell of the entry chain
`timescale 1ns / 1ps

module fwrbv_cell (
  input  logic                                 clk_i,
  input  fwrbv_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [fwrbv_pkg::DATA_W-1:0]  next_i,
  input  logic signed [fwrbv_pkg::DATA_W-1:0]  load_i,
  output logic signed [fwrbv_pkg::DATA_W-1:0]  data_o
);

  logic signed [fwrbv_pkg::DATA_W-1:0] data_q, data_d;

  // load wins over shift
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_i;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/fifo_with_remove_by_value_top.sv -----
// module: top level of the fifo with remove-by-value
`timescale 1ns / 1ps

// A bounded fifo of signed 32-bit values held in a chain of DEPTH cells, the
// oldest entry always in cell 0. Each request beat gives exactly one result
// beat with data_out, status, removed_count and occupancy. Push writes the
// value into the cell just past the tail (status full when DEPTH entries are
// held); pop returns cell 0 and shifts the whole chain one cell towards the
// head (status empty, data 0, on an empty queue). Push, pop and the unused
// request code are done in the accepting cycle. Remove holds the request side
// off until its sweep ends: after the accepting cycle the chain rotates one
// cell per cycle past a single compare at cell 0, each entry that differs
// from the value is written back behind the tail and each match is dropped,
// so the survivors keep their order; a final step emits the result (status
// not found when nothing matched). A result waits in an
// output register, and a new request is taken while the block is idle and
// that register is empty or being drained. removed_count and occupancy are
// 5 bits wide and wrap for DEPTH above 31. The store needs no clearing after
// reset: only occupied cells are ever read.
module fifo_with_remove_by_value_top #(
  parameter int unsigned DEPTH = fwrbv_pkg::DEPTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // request channel
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic        [fwrbv_pkg::REQ_W-1:0]      req_type_i,
  input  logic signed [fwrbv_pkg::DATA_W-1:0]     value_i,
  // result channel
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [fwrbv_pkg::DATA_W-1:0]     data_out_o,
  output logic        [fwrbv_pkg::STAT_W-1:0]     status_o,
  output logic        [fwrbv_pkg::CNT_W-1:0]      removed_count_o,
  output logic        [fwrbv_pkg::CNT_W-1:0]      occupancy_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);  // counts 0..DEPTH
  localparam int unsigned IW = $clog2(DEPTH);      // cell index

  // controller states
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SWEEP = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] count_q, count_d;      // entries held in the chain
  logic [CW-1:0] steps_q, steps_d;      // entries still to pass the head
  logic [CW-1:0] removed_q, removed_d;  // matches dropped so far
  logic signed [fwrbv_pkg::DATA_W-1:0] match_q, match_d;

  // result register
  logic                                out_valid_q, out_valid_d;
  logic signed [fwrbv_pkg::DATA_W-1:0] data_q, data_d;
  logic        [fwrbv_pkg::STAT_W-1:0] stat_q, stat_d;
  logic        [fwrbv_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic        [fwrbv_pkg::CNT_W-1:0]  occ_q, occ_d;

  // chain control
  logic                                shift_all;
  logic                                wr_en;
  logic [IW-1:0]                       wr_idx;
  logic signed [fwrbv_pkg::DATA_W-1:0] wr_data;
  logic signed [fwrbv_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic signed [fwrbv_pkg::DATA_W-1:0] head;
  logic [CW-1:0]                       cnt_dec;
  logic                                accept;
  logic                                out_load;

  assign head       = cell_data[0];
  assign cnt_dec    = count_q - CW'(1);
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    steps_d   = steps_q;
    removed_d = removed_q;
    match_d   = match_q;
    shift_all = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = count_q[IW-1:0];
    wr_data   = value_i;
    out_load  = 1'b0;
    data_d    = data_q;
    stat_d    = fwrbv_pkg::STAT_OK;
    rem_d     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          data_d   = '0;
          case (req_type_i)
            fwrbv_pkg::REQ_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                stat_d = fwrbv_pkg::STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            fwrbv_pkg::REQ_POP: begin
              if (count_q == '0) begin
                stat_d = fwrbv_pkg::STAT_EMPTY;
              end else begin
                data_d    = head;
                shift_all = 1'b1;
                count_d   = cnt_dec;
              end
            end
            fwrbv_pkg::REQ_REMOVE: begin
              // result comes at the end of the sweep
              out_load  = 1'b0;
              state_d   = S_SWEEP;
              steps_d   = count_q;
              removed_d = '0;
              match_d   = value_i;
            end
            default: begin
              // unused code: no change, ok result
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (steps_q != '0) begin
          // rotate the head out; survivors go back behind the tail
          steps_d   = steps_q - CW'(1);
          shift_all = 1'b1;
          if (head == match_q) begin
            count_d   = cnt_dec;
            removed_d = removed_q + CW'(1);
          end else begin
            wr_en   = 1'b1;
            wr_idx  = cnt_dec[IW-1:0];
            wr_data = head;
          end
        end else begin
          out_load = 1'b1;
          data_d   = '0;
          stat_d   = (removed_q == '0) ? fwrbv_pkg::STAT_NOT_FOUND : fwrbv_pkg::STAT_OK;
          rem_d    = fwrbv_pkg::CNT_W'(removed_q);
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    occ_d = fwrbv_pkg::CNT_W'(count_d);
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fwrbv_pkg::cell_ctrl_t                ctrl;
    logic signed [fwrbv_pkg::DATA_W-1:0]  nxt;

    assign ctrl.shift = shift_all;
    assign ctrl.load  = wr_en && (wr_idx == IW'(i));

    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_data[i+1];
    end

    fwrbv_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .next_i (nxt),
      .load_i (wr_data),
      .data_o (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      steps_q     <= '0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      steps_q     <= steps_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (out_load) begin
      data_q <= data_d;
      stat_q <= stat_d;
      rem_q  <= rem_d;
      occ_q  <= occ_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = data_q;
  assign status_o        = stat_q;
  assign removed_count_o = rem_q;
  assign occupancy_o     = occ_q;

`ifndef SYNTHESIS
  // occupancy never goes past the chain length
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // no request is taken during a sweep
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("ready raised outside idle");

  // sweep never has more entries to visit than are held
  a_sweep_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> steps_q <= count_q)
    else $error("sweep step count above occupancy");

  // not found never comes with a removal count
  a_not_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == fwrbv_pkg::STAT_NOT_FOUND |-> removed_count_o == '0)
    else $error("not found beat reports removals");

  // an accepted remove leads into the sweep
  a_remove_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == fwrbv_pkg::REQ_REMOVE |=> state_q == S_SWEEP)
    else $error("remove did not start a sweep");
`endif

endmodule

// ----- sim/tb_top.sv -----
// testbench: directed table then random request beats against a queue-based predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FIFO_DEPTH = fwrbv_pkg::DEPTH_DEF;
  // request code 3 is unused by the block and must leave the queue alone
  localparam logic [fwrbv_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int unsigned PLAN_ROWS = 25;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic signed [fwrbv_pkg::DATA_W-1:0] data;
    logic        [fwrbv_pkg::STAT_W-1:0] status;
    logic        [fwrbv_pkg::CNT_W-1:0]  removed;
    logic        [fwrbv_pkg::CNT_W-1:0]  occ;
  } beat_res_t;

  // one row of the directed table, repeated reps times; fixed rows carry their own result
  typedef struct {
    logic        [fwrbv_pkg::REQ_W-1:0]  req;
    logic signed [fwrbv_pkg::DATA_W-1:0] val;
    int unsigned                         reps;
    bit                                  fixed;
    beat_res_t                           res;
  } plan_row_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic        [fwrbv_pkg::REQ_W-1:0]  req_type_i = fwrbv_pkg::REQ_PUSH;
  logic signed [fwrbv_pkg::DATA_W-1:0] value_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [fwrbv_pkg::DATA_W-1:0] data_out_o;
  logic        [fwrbv_pkg::STAT_W-1:0] status_o;
  logic        [fwrbv_pkg::CNT_W-1:0]  removed_count_o;
  logic        [fwrbv_pkg::CNT_W-1:0]  occupancy_o;

  // travel with the payload so the monitor sees them at the same edge
  bit        beat_fixed = 1'b0;
  beat_res_t beat_res = '0;

  bit        calm = 1'b0;
  int        fault_count = 0;
  int        stall_cycles = 0;

  logic signed [fwrbv_pkg::DATA_W-1:0] held_q [$];   // predictor copy of the queue contents
  beat_res_t                           result_q [$]; // results still owed by the block
  beat_res_t                           seen_res;
  beat_res_t                           want_res;

  // small pool so that removes often find matches
  logic signed [fwrbv_pkg::DATA_W-1:0] value_pool [6] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd100
  };

  plan_row_t plan [PLAN_ROWS];

  fifo_with_remove_by_value_top #(
    .DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_o     (data_out_o),
    .status_o       (status_o),
    .removed_count_o(removed_count_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor: applies one request to the held queue and returns the result beat
  function automatic beat_res_t apply_request(logic [fwrbv_pkg::REQ_W-1:0] req,
                                              logic signed [fwrbv_pkg::DATA_W-1:0] val);
    beat_res_t                           res;
    logic signed [fwrbv_pkg::DATA_W-1:0] kept [$];
    int                                  n_before;
    res = '0;
    res.status = fwrbv_pkg::STAT_OK;
    case (req)
      fwrbv_pkg::REQ_PUSH: begin
        if (held_q.size() >= FIFO_DEPTH) res.status = fwrbv_pkg::STAT_FULL;
        else held_q.push_back(val);
      end
      fwrbv_pkg::REQ_POP: begin
        if (held_q.size() == 0) res.status = fwrbv_pkg::STAT_EMPTY;
        else res.data = held_q.pop_front();
      end
      fwrbv_pkg::REQ_REMOVE: begin
        n_before = held_q.size();
        foreach (held_q[i]) if (held_q[i] != val) kept.push_back(held_q[i]);
        held_q = kept;
        res.removed = fwrbv_pkg::CNT_W'(n_before - kept.size());
        if (res.removed == 0) res.status = fwrbv_pkg::STAT_NOT_FOUND;
      end
      default: ;
    endcase
    res.occ = fwrbv_pkg::CNT_W'(held_q.size());
    return res;
  endfunction

  function automatic void note_fault(string what, beat_res_t want, beat_res_t got);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("tb: %s  expected data=%0d st=%0d rm=%0d occ=%0d",
               what, want.data, want.status, want.removed, want.occ);
      $display("tb: %s  got data=%0d st=%0d rm=%0d occ=%0d",
               what, got.data, got.status, got.removed, got.occ);
    end
  endfunction

  // one request beat; an occasional gap drops valid first, otherwise valid stays high
  task automatic send_beat(input logic [fwrbv_pkg::REQ_W-1:0] req,
                           input logic signed [fwrbv_pkg::DATA_W-1:0] val,
                           input bit fixed, input beat_res_t res);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    beat_fixed <= fixed;
    beat_res   <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // result side back-pressure
  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(0, 99) >= 9);

  // accepted requests feed the predictor, accepted results are checked in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want_res = apply_request(req_type_i, value_i);
        if (beat_fixed) want_res = beat_res;
        result_q.push_back(want_res);
      end
      if (out_valid_o && out_ready_i) begin
        seen_res = '{data_out_o, status_o, removed_count_o, occupancy_o};
        if (result_q.size() == 0) begin
          note_fault("result beat with nothing owed", '0, seen_res);
        end else begin
          want_res = result_q.pop_front();
          if (seen_res.data !== want_res.data || seen_res.status !== want_res.status ||
              seen_res.removed !== want_res.removed || seen_res.occ !== want_res.occ)
            note_fault("result mismatch", want_res, seen_res);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned                         n_items;
    int unsigned                         pick;
    int unsigned                         push_weight;
    logic        [fwrbv_pkg::REQ_W-1:0]  req;
    logic signed [fwrbv_pkg::DATA_W-1:0] val;

    plan = '{
      // empty queue: pop, remove and the spare code
      '{fwrbv_pkg::REQ_POP, 32'sd0, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_EMPTY, 5'd0, 5'd0}},
      '{fwrbv_pkg::REQ_REMOVE, 32'sd5, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_NOT_FOUND, 5'd0, 5'd0}},
      '{REQ_SPARE, -32'sd1, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd0, 5'd0}},
      // value extremes
      '{fwrbv_pkg::REQ_PUSH, 32'sh8000_0000, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd0, 5'd1}},
      '{fwrbv_pkg::REQ_PUSH, 32'sh7fff_ffff, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd0, 5'd2}},
      '{fwrbv_pkg::REQ_PUSH, 32'sd0, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd0, 5'd3}},
      '{fwrbv_pkg::REQ_PUSH, -32'sd1, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd0, 5'd4}},
      '{fwrbv_pkg::REQ_POP, 32'sd0, 1, 1'b1,
        '{32'sh8000_0000, fwrbv_pkg::STAT_OK, 5'd0, 5'd3}},
      '{fwrbv_pkg::REQ_REMOVE, 32'sh7fff_ffff, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd1, 5'd2}},
      '{fwrbv_pkg::REQ_REMOVE, 32'sd12345, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_NOT_FOUND, 5'd0, 5'd2}},
      // fill up, then push into a full queue
      '{fwrbv_pkg::REQ_PUSH, 32'sd7, 14, 1'b0, '0},
      '{fwrbv_pkg::REQ_PUSH, 32'sd1, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_FULL, 5'd0, 5'd16}},
      '{REQ_SPARE, 32'sd0, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd0, 5'd16}},
      // remove many from a full queue, survivors keep their order
      '{fwrbv_pkg::REQ_REMOVE, 32'sd7, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd14, 5'd2}},
      '{fwrbv_pkg::REQ_REMOVE, 32'sd0, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd1, 5'd1}},
      '{fwrbv_pkg::REQ_PUSH, 32'sd42, 1, 1'b0, '0},
      '{fwrbv_pkg::REQ_POP, 32'sd0, 1, 1'b0, '0},
      // pop down to empty, then use the queue again
      '{fwrbv_pkg::REQ_POP, 32'sd0, 1, 1'b0, '0},
      '{fwrbv_pkg::REQ_PUSH, 32'sd9, 1, 1'b0, '0},
      '{fwrbv_pkg::REQ_POP, 32'sd0, 1, 1'b0, '0},
      '{fwrbv_pkg::REQ_POP, 32'sd0, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_EMPTY, 5'd0, 5'd0}},
      // full queue of one value, removed in one go
      '{fwrbv_pkg::REQ_PUSH, 32'sd3, 16, 1'b0, '0},
      '{fwrbv_pkg::REQ_REMOVE, 32'sd3, 1, 1'b1,
        '{32'sd0, fwrbv_pkg::STAT_OK, 5'd16, 5'd0}},
      '{fwrbv_pkg::REQ_PUSH, 32'sd5, 1, 1'b0, '0},
      '{fwrbv_pkg::REQ_POP, 32'sd0, 1, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r])
      repeat (plan[r].reps) send_beat(plan[r].req, plan[r].val, plan[r].fixed, plan[r].res);

    // random phases with a drifting push share, so the queue swings between empty and full
    n_items = 0;
    push_weight = 50;
    while (n_items < RANDOM_ITEMS) begin
      if (n_items % 60 == 0) push_weight = $urandom_range(25, 75);
      calm <= (n_items >= 250 && n_items < 400);
      pick = $urandom_range(0, 99);
      if (pick < 3) req = REQ_SPARE;
      else if (pick < 3 + push_weight) req = fwrbv_pkg::REQ_PUSH;
      else if ($urandom_range(0, 9) < 6) req = fwrbv_pkg::REQ_POP;
      else req = fwrbv_pkg::REQ_REMOVE;
      if ($urandom_range(0, 3) != 0) val = value_pool[$urandom_range(0, 5)];
      else val = $urandom();
      send_beat(req, val, 1'b0, '0);
      n_items++;
    end
    in_valid_i <= 1'b0;
    // let the monitor book the last accepted beat first
    @(posedge clk_i);

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
